### sv/rsi_pkg.sv
// shared constants, codes and types for the ray sphere intersection pipeline
`timescale 1ns / 1ps

package rsi_pkg;

   // number formats
   localparam int FRAC_BITS  = 16;
   localparam int COORD_BITS = 32;

   // derived widths
   localparam int CW  = COORD_BITS;          // coordinate and radius
   localparam int TW  = CW - 1;              // ray parameter
   localparam int PW  = 2 * CW;              // magnitude of a, b, c and single products
   localparam int BW  = 2 * CW + 2;          // signed b and c
   localparam int XW  = 2 * PW;              // b*b and a*c
   localparam int QW  = 4 * CW + 2;          // discriminant, even for digit pairs
   localparam int RW  = QW / 2;              // square root
   localparam int RMW = 2 * CW + 4;          // square root partial remainder
   localparam int NW  = 2 * CW + 3;          // signed root numerators
   localparam int DW  = 3 * CW + FRAC_BITS;  // division remainder and divisor

   // chain lengths
   localparam int SQ_CELLS  = QW / 2;
   localparam int DIV_CELLS = CW - 1;

   // root classification
   localparam logic [1:0] ST_LOW  = 2'd0;    // root not positive
   localparam logic [1:0] ST_DIV  = 2'd1;    // root in range, quotient valid
   localparam logic [1:0] ST_HIGH = 2'd2;    // root beyond the limit

   // side data carried along the square root chain
   typedef struct packed {
      logic                 miss;
      logic [PW-1:0]        a;
      logic signed [BW-1:0] b;
      logic [TW-1:0]        tl;
   } sq_pass_type;

   // side data carried along the divider chain
   typedef struct packed {
      logic          miss;
      logic [TW-1:0] tl;
      logic [1:0]    st0;
      logic [1:0]    st1;
   } dv_pass_type;

   // magnitude of a signed coordinate, the most negative value included
   function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
      return v[CW-1] ? CW'(-v) : CW'(v);
   endfunction

endpackage

### sv/rsi_ifs.sv
// ray request and hit response channel interfaces
`timescale 1ns / 1ps

interface rsi_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rsi_pkg::CW-1:0]       origin_x;
   logic signed [rsi_pkg::CW-1:0]       origin_y;
   logic signed [rsi_pkg::CW-1:0]       origin_z;
   logic signed [rsi_pkg::CW-1:0]       dir_x;
   logic signed [rsi_pkg::CW-1:0]       dir_y;
   logic signed [rsi_pkg::CW-1:0]       dir_z;
   logic [rsi_pkg::TW-1:0]              t_limit;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit,
                   output ready);
endinterface

interface rsi_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [rsi_pkg::TW-1:0] t_hit;

   modport source (output valid, hit, t_hit, input ready);
   modport sink   (input valid, hit, t_hit, output ready);
endinterface

### sv/rsi_front.sv
// quadratic coefficients and discriminant, five register stages
`timescale 1ns / 1ps

module rsi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [rsi_pkg::CW-1:0] org [3],
   input  logic signed [rsi_pkg::CW-1:0] dir [3],
   input  logic [rsi_pkg::TW-1:0]        t_limit,
   input  logic [rsi_pkg::CW-1:0]        radius,
   output logic                          out_valid,
   output logic [rsi_pkg::QW-1:0]        q,
   output rsi_pkg::sq_pass_type          pass
);
   import rsi_pkg::*;

   // stage 1 signals
   logic [CW-1:0] om [3];
   logic [CW-1:0] dm [3];
   logic [PW-1:0] dd_in [3], dd_ff [3];
   logic [PW-1:0] oo_in [3], oo_ff [3];
   logic [PW-1:0] od_in [3], od_ff [3];
   logic [2:0]    odn_in, odn_ff;
   logic [PW-1:0] rr_in, rr_ff;
   logic [TW-1:0] tl1_ff;
   logic          v1_ff;

   // stage 2 signals
   logic signed [BW-1:0] bt [3];
   logic [PW-1:0]        a2_in, a2_ff;
   logic [PW-1:0]        oos;
   logic signed [BW-1:0] b2_in, b2_ff;
   logic signed [BW-1:0] c2_in, c2_ff;
   logic [TW-1:0]        tl2_ff;
   logic                 v2_ff;

   // stage 3 signals
   logic [PW-1:0]        bm, cm;
   logic [PW-1:0]        bhh_in, bhl_in, bll_in, bhh_ff, bhl_ff, bll_ff;
   logic [PW-1:0]        ahh_in, ahl_in, alh_in, all_in, ahh_ff, ahl_ff, alh_ff, all_ff;
   logic [PW-1:0]        a3_ff;
   logic signed [BW-1:0] b3_ff;
   logic                 cn3_ff;
   logic [TW-1:0]        tl3_ff;
   logic                 v3_ff;

   // stage 4 signals
   logic [XW-1:0]        bsq_in, bsq_ff, acm_in, acm_ff;
   logic [PW-1:0]        a4_ff;
   logic signed [BW-1:0] b4_ff;
   logic                 cn4_ff;
   logic [TW-1:0]        tl4_ff;
   logic                 v4_ff;

   // stage 5 signals
   logic [QW-1:0] qs;
   logic          miss_in;
   logic [QW-1:0] q_ff;
   sq_pass_type   pass_ff;
   logic          v5_ff;

   // stage 1: magnitudes and single products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         om[i]     = mag(org[i]);
         dm[i]     = mag(dir[i]);
         dd_in[i]  = dm[i] * dm[i];
         oo_in[i]  = om[i] * om[i];
         od_in[i]  = om[i] * dm[i];
         odn_in[i] = org[i][CW-1] ^ dir[i][CW-1];
      end
      rr_in = radius * radius;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         dd_ff  <= dd_in;
         oo_ff  <= oo_in;
         od_ff  <= od_in;
         odn_ff <= odn_in;
         rr_ff  <= rr_in;
         tl1_ff <= t_limit;
      end
   end

   // stage 2: dot products and c
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bt[i] = odn_ff[i] ? -$signed(BW'(od_ff[i])) : $signed(BW'(od_ff[i]));
      end
      a2_in = dd_ff[0] + dd_ff[1] + dd_ff[2];
      oos   = oo_ff[0] + oo_ff[1] + oo_ff[2];
      b2_in = bt[0] + bt[1] + bt[2];
      c2_in = $signed(BW'(oos)) - $signed(BW'(rr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
         c2_ff  <= c2_in;
         tl2_ff <= tl1_ff;
      end
   end

   // stage 3: half word partial products of b*b and a*c
   always_comb begin
      bm     = b2_ff[BW-1] ? PW'(-b2_ff) : PW'(b2_ff);
      cm     = c2_ff[BW-1] ? PW'(-c2_ff) : PW'(c2_ff);
      bhh_in = bm[PW-1:CW] * bm[PW-1:CW];
      bhl_in = bm[PW-1:CW] * bm[CW-1:0];
      bll_in = bm[CW-1:0] * bm[CW-1:0];
      ahh_in = a2_ff[PW-1:CW] * cm[PW-1:CW];
      ahl_in = a2_ff[PW-1:CW] * cm[CW-1:0];
      alh_in = a2_ff[CW-1:0] * cm[PW-1:CW];
      all_in = a2_ff[CW-1:0] * cm[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         bhh_ff <= bhh_in;
         bhl_ff <= bhl_in;
         bll_ff <= bll_in;
         ahh_ff <= ahh_in;
         ahl_ff <= ahl_in;
         alh_ff <= alh_in;
         all_ff <= all_in;
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         cn3_ff <= c2_ff[BW-1];
         tl3_ff <= tl2_ff;
      end
   end

   // stage 4: assemble the wide products
   always_comb begin
      bsq_in = (XW'(bhh_ff) << PW) + (XW'(bhl_ff) << (CW + 1)) + XW'(bll_ff);
      acm_in = (XW'(ahh_ff) << PW) + ((XW'(ahl_ff) + XW'(alh_ff)) << CW) + XW'(all_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         bsq_ff <= bsq_in;
         acm_ff <= acm_in;
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         cn4_ff <= cn3_ff;
         tl4_ff <= tl3_ff;
      end
   end

   // stage 5: discriminant and early miss
   always_comb begin
      qs      = cn4_ff ? QW'(bsq_ff) + QW'(acm_ff) : QW'(bsq_ff) - QW'(acm_ff);
      miss_in = (a4_ff == '0) || qs[QW-1] || (qs == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         q_ff         <= qs;
         pass_ff.miss <= miss_in;
         pass_ff.a    <= a4_ff;
         pass_ff.b    <= b4_ff;
         pass_ff.tl   <= tl4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign q         = q_ff;
   assign pass      = pass_ff;

endmodule

### sv/rsi_sqrt_cell.sv
// one digit pair step of the integer square root chain
`timescale 1ns / 1ps

module rsi_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    v_i,
   input  logic [rsi_pkg::RMW-1:0] rem_i,
   input  logic [rsi_pkg::RW-1:0]  root_i,
   input  logic [rsi_pkg::QW-1:0]  qr_i,
   input  rsi_pkg::sq_pass_type    pass_i,
   output logic                    v_o,
   output logic [rsi_pkg::RMW-1:0] rem_o,
   output logic [rsi_pkg::RW-1:0]  root_o,
   output logic [rsi_pkg::QW-1:0]  qr_o,
   output rsi_pkg::sq_pass_type    pass_o
);
   import rsi_pkg::*;

   logic [RMW-1:0] rem_sh, trial;
   logic [RMW-1:0] rem_in, rem_ff;
   logic [RW-1:0]  root_in, root_ff;
   logic [QW-1:0]  qr_ff;
   sq_pass_type    pass_ff;
   logic           v_ff;

   // bring down the next digit pair and try the next root bit
   always_comb begin
      rem_sh = {rem_i[RMW-3:0], qr_i[QW-1:QW-2]};
      trial  = RMW'({root_i, 2'b01});
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_i[RW-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_i[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_i;
      end
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         qr_ff   <= {qr_i[QW-3:0], 2'b00};
         pass_ff <= pass_i;
      end
   end

   assign v_o    = v_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign qr_o   = qr_ff;
   assign pass_o = pass_ff;

endmodule

### sv/rsi_div_cell.sv
// one quotient bit step for both root divisions
`timescale 1ns / 1ps

module rsi_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   v_i,
   input  logic [rsi_pkg::DW-1:0] rem0_i,
   input  logic [rsi_pkg::DW-1:0] rem1_i,
   input  logic [rsi_pkg::TW-1:0] quot0_i,
   input  logic [rsi_pkg::TW-1:0] quot1_i,
   input  logic [rsi_pkg::DW-1:0] dvs_i,
   input  rsi_pkg::dv_pass_type   pass_i,
   output logic                   v_o,
   output logic [rsi_pkg::DW-1:0] rem0_o,
   output logic [rsi_pkg::DW-1:0] rem1_o,
   output logic [rsi_pkg::TW-1:0] quot0_o,
   output logic [rsi_pkg::TW-1:0] quot1_o,
   output logic [rsi_pkg::DW-1:0] dvs_o,
   output rsi_pkg::dv_pass_type   pass_o
);
   import rsi_pkg::*;

   logic          ge0, ge1;
   logic [DW-1:0] rem0_ff, rem1_ff, dvs_ff;
   logic [TW-1:0] quot0_ff, quot1_ff;
   dv_pass_type   pass_ff;
   logic          v_ff;

   // restoring step against the shifted divisor
   always_comb begin
      ge0 = rem0_i >= dvs_i;
      ge1 = rem1_i >= dvs_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_i;
      end
      if (en) begin
         rem0_ff  <= ge0 ? rem0_i - dvs_i : rem0_i;
         rem1_ff  <= ge1 ? rem1_i - dvs_i : rem1_i;
         quot0_ff <= {quot0_i[TW-2:0], ge0};
         quot1_ff <= {quot1_i[TW-2:0], ge1};
         dvs_ff   <= dvs_i >> 1;
         pass_ff  <= pass_i;
      end
   end

   assign v_o     = v_ff;
   assign rem0_o  = rem0_ff;
   assign rem1_o  = rem1_ff;
   assign quot0_o = quot0_ff;
   assign quot1_o = quot1_ff;
   assign dvs_o   = dvs_ff;
   assign pass_o  = pass_ff;

endmodule

### sv/ray_sphere_intersect.sv
// request word to response word: 5 coefficient stages, one square root cell per digit
// pair (65), numerator and range stages, one divider cell per quotient bit (31), output
// register; one ray per cycle sustained while the response register does not hold
// the whole pipeline holds while the response register is full and not taken
// synchronous reset empties the pipeline and sets the radius to 1.0
`timescale 1ns / 1ps

module ray_sphere_intersect (
   input  logic                   clock,
   input  logic                   reset,
   rsi_req_if.sink                req_ch,
   rsi_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [rsi_pkg::CW-1:0] csr_wr_data
);
   import rsi_pkg::*;

   logic          en;
   logic [CW-1:0] radius_ff;
   logic signed [CW-1:0] org [3];
   logic signed [CW-1:0] dir [3];

   // square root chain links
   logic           sq_v    [SQ_CELLS+1];
   logic [RMW-1:0] sq_rem  [SQ_CELLS+1];
   logic [RW-1:0]  sq_root [SQ_CELLS+1];
   logic [QW-1:0]  sq_qr   [SQ_CELLS+1];
   sq_pass_type    sq_pass [SQ_CELLS+1];

   // numerator stage
   logic signed [NW-1:0] bx, sx;
   logic signed [NW-1:0] n0_ff, n1_ff;
   logic [PW-1:0]        an_ff;
   logic [TW-1:0]        tln_ff;
   logic                 missn_ff;
   logic                 vn_ff;

   // range stage
   logic [DW-1:0] m0, m1, ad, ahi;
   logic [1:0]    st0_in, st1_in;

   // divider chain links
   logic          dv_v     [DIV_CELLS+1];
   logic [DW-1:0] dv_rem0  [DIV_CELLS+1];
   logic [DW-1:0] dv_rem1  [DIV_CELLS+1];
   logic [TW-1:0] dv_quot0 [DIV_CELLS+1];
   logic [TW-1:0] dv_quot1 [DIV_CELLS+1];
   logic [DW-1:0] dv_dvs   [DIV_CELLS+1];
   dv_pass_type   dv_pass  [DIV_CELLS+1];
   logic          vk_ff;
   logic [DW-1:0] rem0_ff, rem1_ff, dvs_ff;
   dv_pass_type   passk_ff;

   // result stage
   logic [1:0]    r0, r1;
   logic          use0, hit_in;
   logic [TW-1:0] t_in;
   logic          rsp_valid_ff, hit_ff;
   logic [TW-1:0] t_ff;

   // pipeline advances unless a held response blocks it
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= CW'(1) << FRAC_BITS;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign org[0] = req_ch.origin_x;
   assign org[1] = req_ch.origin_y;
   assign org[2] = req_ch.origin_z;
   assign dir[0] = req_ch.dir_x;
   assign dir[1] = req_ch.dir_y;
   assign dir[2] = req_ch.dir_z;

   // coefficients and discriminant
   rsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .org       (org),
      .dir       (dir),
      .t_limit   (req_ch.t_limit),
      .radius    (radius_ff),
      .out_valid (sq_v[0]),
      .q         (sq_qr[0]),
      .pass      (sq_pass[0])
   );

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   // square root chain, one root bit per cell
   for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
      rsi_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .v_i    (sq_v[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .qr_i   (sq_qr[i]),
         .pass_i (sq_pass[i]),
         .v_o    (sq_v[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .qr_o   (sq_qr[i+1]),
         .pass_o (sq_pass[i+1])
      );
   end

   // near and far numerators -b - s and -b + s
   always_comb begin
      bx = NW'(sq_pass[SQ_CELLS].b);
      sx = NW'(sq_root[SQ_CELLS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= sq_v[SQ_CELLS];
      end
      if (en) begin
         n0_ff    <= -bx - sx;
         n1_ff    <= -bx + sx;
         an_ff    <= sq_pass[SQ_CELLS].a;
         tln_ff   <= sq_pass[SQ_CELLS].tl;
         missn_ff <= sq_pass[SQ_CELLS].miss;
      end
   end

   // classify each root: not positive, beyond quotient range, or to divide
   always_comb begin
      m0  = DW'(n0_ff[NW-2:0]) << FRAC_BITS;
      m1  = DW'(n1_ff[NW-2:0]) << FRAC_BITS;
      ad  = DW'(an_ff);
      ahi = ad << (CW - 1);
      if (n0_ff[NW-1] || (n0_ff == '0) || (m0 < ad)) begin
         st0_in = ST_LOW;
      end else if (m0 >= ahi) begin
         st0_in = ST_HIGH;
      end else begin
         st0_in = ST_DIV;
      end
      if (n1_ff[NW-1] || (n1_ff == '0) || (m1 < ad)) begin
         st1_in = ST_LOW;
      end else if (m1 >= ahi) begin
         st1_in = ST_HIGH;
      end else begin
         st1_in = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vk_ff <= 1'b0;
      end else if (en) begin
         vk_ff <= vn_ff;
      end
      if (en) begin
         rem0_ff       <= m0;
         rem1_ff       <= m1;
         dvs_ff        <= ad << (CW - 2);
         passk_ff.miss <= missn_ff;
         passk_ff.tl   <= tln_ff;
         passk_ff.st0  <= st0_in;
         passk_ff.st1  <= st1_in;
      end
   end

   assign dv_v[0]     = vk_ff;
   assign dv_rem0[0]  = rem0_ff;
   assign dv_rem1[0]  = rem1_ff;
   assign dv_quot0[0] = '0;
   assign dv_quot1[0] = '0;
   assign dv_dvs[0]   = dvs_ff;
   assign dv_pass[0]  = passk_ff;

   // divider chain, one quotient bit per cell, both roots side by side
   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_dv
      rsi_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .v_i     (dv_v[k]),
         .rem0_i  (dv_rem0[k]),
         .rem1_i  (dv_rem1[k]),
         .quot0_i (dv_quot0[k]),
         .quot1_i (dv_quot1[k]),
         .dvs_i   (dv_dvs[k]),
         .pass_i  (dv_pass[k]),
         .v_o     (dv_v[k+1]),
         .rem0_o  (dv_rem0[k+1]),
         .rem1_o  (dv_rem1[k+1]),
         .quot0_o (dv_quot0[k+1]),
         .quot1_o (dv_quot1[k+1]),
         .dvs_o   (dv_dvs[k+1]),
         .pass_o  (dv_pass[k+1])
      );
   end

   // pick the near root if positive, else the far one, and check the limit
   always_comb begin
      r0 = dv_pass[DIV_CELLS].st0;
      r1 = dv_pass[DIV_CELLS].st1;
      if ((r0 == ST_DIV) && (dv_quot0[DIV_CELLS] > dv_pass[DIV_CELLS].tl)) begin
         r0 = ST_HIGH;
      end
      if ((r1 == ST_DIV) && (dv_quot1[DIV_CELLS] > dv_pass[DIV_CELLS].tl)) begin
         r1 = ST_HIGH;
      end
      use0   = r0 != ST_LOW;
      hit_in = !dv_pass[DIV_CELLS].miss && (use0 ? (r0 == ST_DIV) : (r1 == ST_DIV));
      if (!hit_in) begin
         t_in = '0;
      end else if (use0) begin
         t_in = dv_quot0[DIV_CELLS];
      end else begin
         t_in = dv_quot1[DIV_CELLS];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_v[DIV_CELLS];
      end
      if (en) begin
         hit_ff <= hit_in;
         t_ff   <= t_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit   = hit_ff;
   assign rsp_ch.t_hit = t_ff;

endmodule
